@@ rtl/core/btsp_pkg.sv @@
// Shared types, codes and constants of the BER TLV stream parser.
`default_nettype none
package btsp_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int IDX_W     = $clog2(MAX_DEPTH);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int LEN_W     = 64;
    localparam int TAG_W     = 32;
    localparam int LBL_W     = 4;
    localparam int OUT_DATA_W = 120;

    typedef enum logic [2:0] {
        KIND_PENDING = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_END     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_INDEFINITE = 3'd1,
        ERR_LEN_BYTES  = 3'd2,
        ERR_DEPTH      = 3'd3,
        ERR_OVERRUN    = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        PH_ID    = 3'd0,
        PH_TAGH  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENM  = 3'd3,
        PH_VALUE = 3'd4,
        PH_ERROR = 3'd5
    } phase_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_CLOSE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic pop;
    } dp_cmd_t;

    typedef struct packed {
        logic close_needed;
        logic close_more;
    } dp_status_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         tag_class;
        logic               constructed;
        logic [TAG_W-1:0]   tag_number;
        logic [LEN_W-1:0]   length;
        logic [4:0]         depth;
        logic [7:0]         value_byte;
        err_t               error_code;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/btsp_ctrl.sv @@
// Controller: input/output handshake and the end-event burst sequencer.
`default_nettype none
module btsp_ctrl
    import btsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Decode commands from state and handshakes
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE) && slot_free;
        cmd.step = in_ready && in_valid;
        cmd.pop  = (state_reg == ST_CLOSE) && slot_free;
        out_valid = out_valid_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.step && status.close_needed)
                    state_next = ST_CLOSE;
            end
            ST_CLOSE:
            begin
                if (cmd.pop && !status.close_more)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        if (cmd.step || cmd.pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/btsp_datapath.sv @@
// Datapath: header decode registers, nesting count stack and result register.
`default_nettype none
module btsp_datapath
    import btsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    output result_t         result
);

    phase_t             phase_reg, phase_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [2:0]         cf_reg, cf_next;
    logic [LEN_W-1:0]   lacc_reg, lacc_next;
    logic [LBL_W-1:0]   lbl_reg, lbl_next;
    logic [LEN_W-1:0]   vbl_reg, vbl_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    err_t               held_reg, held_next;
    logic [LEN_W-1:0]   stack_reg [MAX_DEPTH];
    logic [LEN_W-1:0]   dec [MAX_DEPTH];
    result_t            res_reg, step_res, pop_res;

    logic [IDX_W-1:0]   top_idx, pop_idx;
    logic [LEN_W-1:0]   parent;
    logic               top_empty;
    logic [LEN_W-1:0]   acc_shift;
    logic [DEPTH_W-1:0] depth_dec;
    logic               hdr, fail, push, close_needed, close_more;
    logic [LEN_W-1:0]   hlen;
    err_t               fcode;

    // Count one byte against every open element
    always_comb
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            if ((DEPTH_W'(i) < depth_reg) && (stack_reg[i] != '0))
                dec[i] = stack_reg[i] - LEN_W'(1);
            else
                dec[i] = stack_reg[i];
        end
    end

    assign top_idx   = IDX_W'(depth_reg - DEPTH_W'(1));
    assign parent    = dec[top_idx];
    assign top_empty = (depth_reg != '0) && (parent == '0);
    assign acc_shift = {lacc_reg[LEN_W-9:0], data_byte};
    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign pop_idx   = IDX_W'(depth_reg - DEPTH_W'(2));
    assign close_more = (depth_dec != '0) && (stack_reg[pop_idx] == '0);

    // Step one byte through the header/value decoder
    always_comb
    begin
        phase_next   = phase_reg;
        tag_next     = tag_reg;
        cf_next      = cf_reg;
        lacc_next    = lacc_reg;
        lbl_next     = lbl_reg;
        vbl_next     = vbl_reg;
        depth_next   = depth_reg;
        held_next    = held_reg;
        hdr          = 1'b0;
        hlen         = '0;
        fail         = 1'b0;
        fcode        = ERR_NONE;
        push         = 1'b0;
        close_needed = 1'b0;

        step_res             = '0;
        step_res.kind        = KIND_PENDING;
        step_res.error_code  = ERR_NONE;
        step_res.depth       = 5'(depth_reg);

        unique case (phase_reg)
            PH_ID:
            begin
                cf_next = {data_byte[7:6], data_byte[5]};
                if (data_byte[4:0] == 5'd31)
                begin
                    tag_next   = '0;
                    phase_next = PH_TAGH;
                end
                else
                begin
                    tag_next   = TAG_W'(data_byte[4:0]);
                    phase_next = PH_LEN1;
                end
                if (top_empty)
                begin
                    fail  = 1'b1;
                    fcode = ERR_OVERRUN;
                end
            end
            PH_TAGH:
            begin
                tag_next = {tag_reg[TAG_W-8:0], data_byte[6:0]};
                if (!data_byte[7])
                    phase_next = PH_LEN1;
                if (top_empty)
                begin
                    fail  = 1'b1;
                    fcode = ERR_OVERRUN;
                end
            end
            PH_LEN1:
            begin
                if (!data_byte[7])
                begin
                    hdr  = 1'b1;
                    hlen = LEN_W'(data_byte);
                end
                else if (data_byte[6:0] == 7'd0)
                begin
                    fail  = 1'b1;
                    fcode = ERR_INDEFINITE;
                end
                else if (data_byte[6:0] > 7'd8)
                begin
                    fail  = 1'b1;
                    fcode = ERR_LEN_BYTES;
                end
                else
                begin
                    lacc_next  = '0;
                    lbl_next   = data_byte[LBL_W-1:0];
                    phase_next = PH_LENM;
                    if (top_empty)
                    begin
                        fail  = 1'b1;
                        fcode = ERR_OVERRUN;
                    end
                end
            end
            PH_LENM:
            begin
                lacc_next = acc_shift;
                lbl_next  = (lbl_reg != '0) ? lbl_reg - LBL_W'(1) : lbl_reg;
                if (lbl_next == '0)
                begin
                    hdr  = 1'b1;
                    hlen = acc_shift;
                end
                else if (top_empty)
                begin
                    fail  = 1'b1;
                    fcode = ERR_OVERRUN;
                end
            end
            PH_VALUE:
            begin
                step_res.kind       = KIND_VALUE;
                step_res.value_byte = data_byte;
                vbl_next = (vbl_reg != '0) ? vbl_reg - LEN_W'(1) : vbl_reg;
                if (vbl_next == '0)
                begin
                    phase_next   = PH_ID;
                    close_needed = top_empty;
                end
            end
            PH_ERROR:
            begin
                step_res.kind       = KIND_ERROR;
                step_res.error_code = held_reg;
            end
            default:
            begin
                step_res.kind       = KIND_ERROR;
                step_res.error_code = held_reg;
            end
        endcase

        // Finish a complete header
        if (hdr)
        begin
            if ((depth_reg != '0) && (hlen > parent))
            begin
                fail  = 1'b1;
                fcode = ERR_OVERRUN;
            end
            else if ((depth_reg == '0) || cf_reg[0])
            begin
                if (depth_reg >= DEPTH_W'(MAX_DEPTH))
                begin
                    fail  = 1'b1;
                    fcode = ERR_DEPTH;
                end
                else
                begin
                    push         = 1'b1;
                    depth_next   = depth_reg + DEPTH_W'(1);
                    phase_next   = PH_ID;
                    close_needed = (hlen == '0);
                end
            end
            else if (hlen == '0)
            begin
                phase_next   = PH_ID;
                close_needed = top_empty;
            end
            else
            begin
                vbl_next   = hlen;
                phase_next = PH_VALUE;
            end
            if (!fail)
            begin
                step_res.kind        = KIND_HEADER;
                step_res.tag_class   = cf_reg[2:1];
                step_res.constructed = cf_reg[0];
                step_res.tag_number  = tag_reg;
                step_res.length      = hlen;
            end
        end

        // Enter the error phase
        if (fail)
        begin
            phase_next           = PH_ERROR;
            held_next            = fcode;
            push                 = 1'b0;
            close_needed         = 1'b0;
            step_res             = '0;
            step_res.kind        = KIND_ERROR;
            step_res.error_code  = fcode;
            step_res.depth       = 5'(depth_reg);
        end
        step_res.last = !close_needed;
    end

    // End event for the innermost used-up element
    always_comb
    begin
        pop_res            = '0;
        pop_res.kind       = KIND_END;
        pop_res.error_code = ERR_NONE;
        pop_res.depth      = 5'(depth_dec);
        pop_res.last       = !close_more;
    end

    assign status.close_needed = close_needed;
    assign status.close_more   = close_more;
    assign result              = res_reg;

    // Parser control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            tag_reg   <= '0;
            cf_reg    <= '0;
            lacc_reg  <= '0;
            lbl_reg   <= '0;
            vbl_reg   <= '0;
            depth_reg <= '0;
            held_reg  <= ERR_NONE;
        end
        else if (cmd.step)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            cf_reg    <= cf_next;
            lacc_reg  <= lacc_next;
            lbl_reg   <= lbl_next;
            vbl_reg   <= vbl_next;
            depth_reg <= depth_next;
            held_reg  <= held_next;
        end
        else if (cmd.pop)
        begin
            depth_reg <= depth_dec;
        end
    end

    // Remaining count stack and result register
    always_ff @(posedge clk)
    begin
        if (cmd.step && (phase_reg != PH_ERROR))
        begin
            for (int i = 0; i < MAX_DEPTH; i++)
                stack_reg[i] <= dec[i];
            if (push)
                stack_reg[IDX_W'(depth_reg)] <= hlen;
        end
        if (cmd.step)
            res_reg <= step_res;
        else if (cmd.pop)
            res_reg <= pop_res;
    end

endmodule
`default_nettype wire

@@ rtl/core/ber_tlv_stream_parser_unit.sv @@
// Top level of the BER TLV stream parser: controller plus datapath.
//
// Usage:
//   The slave channel takes one byte of a BER stream per transaction. The
//   master channel returns parse events: tuser carries the event kind and
//   tlast marks the final event caused by an input byte.
//   Every byte yields one event through the output register, shown in the
//   cycle after the byte is taken. A byte that completes elements whose
//   parents are used up then yields one extra end event per closed level,
//   one per cycle while the receiver is ready; the input is held off during
//   that burst. Otherwise the sustained rate is one byte per cycle while the
//   receiver keeps up.
//   A stalled receiver holds the result register and the input stays held
//   off until the waiting event is taken.
//   Reset clears the parser to expect an identifier byte at depth zero.
//   After an error every further byte is answered with the held error.
`default_nettype none
module ber_tlv_stream_parser_unit
    import btsp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // data_byte
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tag_class, constructed, tag_number, length, depth, value_byte, error_code
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [2:0]                 m_axis_tuser,   // kind
    output logic                       m_axis_tlast    // last
);

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    btsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    btsp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Pack the result fields, lowest first
    assign m_axis_tdata = {5'd0, result.error_code, result.value_byte, result.depth,
                           result.length, result.tag_number, result.constructed,
                           result.tag_class};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule
`default_nettype wire

@@ verif/ber_tlv_parser_checker.sv @@
// Event checker for the BER TLV stream parser: predicts parse events and compares them.
module ber_tlv_parser_checker
    import btsp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic [2:0]            m_axis_tuser,
    input  wire logic                  m_axis_tlast,
    output int                         fail_count,
    output int                         events_waiting,
    output int                         events_checked
);

    // Parser model state
    phase_t      ph;
    logic [31:0] tag_acc;
    logic [2:0]  cls_form;
    logic [63:0] len_acc;
    int          len_left;
    logic [63:0] val_left;
    int          lvl;
    logic [63:0] remain [MAX_DEPTH];
    err_t        held_err;

    result_t     byte_events [$];
    result_t     parse_events [$];

    assign events_waiting = parse_events.size();

    function automatic void add_event(kind_t k, logic [1:0] c, logic cons, logic [31:0] tg,
                                      logic [63:0] ln, int d, logic [7:0] vb, err_t e);
        result_t r;
        r.kind        = k;
        r.tag_class   = (k == KIND_HEADER) ? c : 2'd0;
        r.constructed = (k == KIND_HEADER) ? cons : 1'b0;
        r.tag_number  = tg;
        r.length      = ln;
        r.depth       = d[4:0];
        r.value_byte  = vb;
        r.error_code  = e;
        r.last        = 1'b0;
        byte_events.push_back(r);
    endfunction

    function automatic void raise_error(err_t e);
        ph       = PH_ERROR;
        held_err = e;
        add_event(KIND_ERROR, 0, 0, 0, 0, lvl, 0, e);
    endfunction

    function automatic void pending_or_overrun(logic top_empty);
        if (top_empty)
            raise_error(ERR_OVERRUN);
        else
            add_event(KIND_PENDING, 0, 0, 0, 0, lvl, 0, ERR_NONE);
    endfunction

    // Pop every enclosing element whose contents are used up, innermost first
    function automatic void close_levels();
        while (lvl > 0 && remain[lvl-1] == 0) begin
            lvl--;
            add_event(KIND_END, 0, 0, 0, 0, lvl, 0, ERR_NONE);
        end
    endfunction

    function automatic void finish_header(logic [63:0] ln);
        int d;
        d = lvl;
        if (d > 0 && ln > remain[d-1]) begin
            raise_error(ERR_OVERRUN);
            return;
        end
        if (d == 0 || cls_form[0]) begin
            if (d >= MAX_DEPTH) begin
                raise_error(ERR_DEPTH);
                return;
            end
            add_event(KIND_HEADER, cls_form[2:1], cls_form[0], tag_acc, ln, d, 0, ERR_NONE);
            remain[d] = ln;
            lvl       = d + 1;
            ph        = PH_ID;
            close_levels();
            return;
        end
        add_event(KIND_HEADER, cls_form[2:1], cls_form[0], tag_acc, ln, d, 0, ERR_NONE);
        if (ln == 0) begin
            ph = PH_ID;
            close_levels();
        end
        else begin
            val_left = ln;
            ph       = PH_VALUE;
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic top_empty;
        if (ph == PH_ERROR) begin
            add_event(KIND_ERROR, 0, 0, 0, 0, lvl, 0, held_err);
        end
        else begin
            // every byte counts against all open enclosing elements
            for (int i = 0; i < lvl && i < MAX_DEPTH; i++)
                if (remain[i] > 0)
                    remain[i]--;
            top_empty = (lvl > 0) && (remain[lvl-1] == 0);
            case (ph)
                PH_ID: begin
                    cls_form = {b[7:6], b[5]};
                    if (b[4:0] == 5'd31) begin
                        tag_acc = 0;
                        ph      = PH_TAGH;
                    end
                    else begin
                        tag_acc = {27'd0, b[4:0]};
                        ph      = PH_LEN1;
                    end
                    pending_or_overrun(top_empty);
                end
                PH_TAGH: begin
                    tag_acc = {tag_acc[24:0], b[6:0]};
                    if (!b[7])
                        ph = PH_LEN1;
                    pending_or_overrun(top_empty);
                end
                PH_LEN1: begin
                    if (!b[7])
                        finish_header({56'd0, b});
                    else if (b == 8'h80)
                        raise_error(ERR_INDEFINITE);
                    else if (b[6:0] > 7'd8)
                        raise_error(ERR_LEN_BYTES);
                    else begin
                        len_acc  = 0;
                        len_left = b[6:0];
                        ph       = PH_LENM;
                        pending_or_overrun(top_empty);
                    end
                end
                PH_LENM: begin
                    len_acc = {len_acc[55:0], b};
                    if (len_left > 0)
                        len_left--;
                    if (len_left == 0)
                        finish_header(len_acc);
                    else
                        pending_or_overrun(top_empty);
                end
                default: begin
                    add_event(KIND_VALUE, 0, 0, 0, 0, lvl, b, ERR_NONE);
                    if (val_left > 0)
                        val_left--;
                    if (val_left == 0) begin
                        ph = PH_ID;
                        close_levels();
                    end
                end
            endcase
        end
        byte_events[$].last = 1'b1;
        while (byte_events.size() > 0)
            parse_events.push_back(byte_events.pop_front());
    endfunction

    // Predict on input transactions, compare on output transactions
    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            ph             = PH_ID;
            tag_acc        = 0;
            cls_form       = 0;
            len_acc        = 0;
            len_left       = 0;
            val_left       = 0;
            lvl            = 0;
            held_err       = ERR_NONE;
            fail_count     = 0;
            events_checked = 0;
            for (int i = 0; i < MAX_DEPTH; i++)
                remain[i] = 0;
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind        = kind_t'(m_axis_tuser);
                got.tag_class   = m_axis_tdata[1:0];
                got.constructed = m_axis_tdata[2];
                got.tag_number  = m_axis_tdata[34:3];
                got.length      = m_axis_tdata[98:35];
                got.depth       = m_axis_tdata[103:99];
                got.value_byte  = m_axis_tdata[111:104];
                got.error_code  = err_t'(m_axis_tdata[114:112]);
                got.last        = m_axis_tlast;
                events_checked++;
                if (parse_events.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected event: kind=%0d depth=%0d",
                                 got.kind, got.depth);
                end
                else begin
                    want = parse_events.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"event mismatch:\n  exp kind=%0d cls=%0d c=%0d tag=%h",
                                      " len=%h dep=%0d vb=%h err=%0d last=%0d\n",
                                      "  got kind=%0d cls=%0d c=%0d tag=%h",
                                      " len=%h dep=%0d vb=%h err=%0d last=%0d"},
                                     want.kind, want.tag_class, want.constructed,
                                     want.tag_number, want.length, want.depth,
                                     want.value_byte, want.error_code, want.last,
                                     got.kind, got.tag_class, got.constructed,
                                     got.tag_number, got.length, got.depth,
                                     got.value_byte, got.error_code, got.last);
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the BER TLV stream parser: byte stimulus, stalls and verdict.
module tb;
    import btsp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef logic [7:0] byte_list_t [$];

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int  fail_count;
    int  events_waiting;
    int  events_checked;
    int  cycles;
    int  rx_hold;
    int  rx_gap;
    logic byte_taken;
    byte_list_t ber_stream;
    int  final_error;

    ber_tlv_stream_parser_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    ber_tlv_parser_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .fail_count     (fail_count),
        .events_waiting (events_waiting),
        .events_checked (events_checked)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Register the input handshake so the sender sees it without a race
    always @(posedge clk)
        byte_taken <= s_axis_tvalid && s_axis_tready;

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk) begin
        if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (rx_gap > 0) begin
            rx_gap        <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else if (cycles % 2000 < 600) begin
            m_axis_tready <= 1'b1;
        end
        else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_gap <= short_gap();
        end
    end

    // Encode a content length in short or long form
    function automatic byte_list_t encode_length(logic [63:0] ln, logic force_long);
        byte_list_t q;
        int nb;
        nb = 1;
        while (nb < 8 && (ln >> (8 * nb)) != 0)
            nb++;
        if (ln < 128 && !force_long) begin
            q.push_back(ln[7:0]);
        end
        else begin
            if (force_long && ln < 128)
                nb = $urandom_range(nb, 8);
            q.push_back(8'h80 | nb[7:0]);
            for (int i = nb - 1; i >= 0; i--)
                q.push_back(ln[8*i +: 8]);
        end
        return q;
    endfunction

    // Build one well-formed element with random tag, form and content
    function automatic byte_list_t make_element(int level);
        byte_list_t q;
        byte_list_t body;
        byte_list_t part;
        logic [34:0] tg;
        logic cons;
        int nt;
        cons = (level == 0) ? 1'($urandom_range(0, 1))
                            : ($urandom_range(0, 2) == 0 && level < 4);
        if (level == 0 || cons) begin
            repeat ($urandom_range(0, 3)) begin
                part = make_element(level + 1);
                body = {body, part};
            end
        end
        else begin
            repeat ($urandom_range(0, 6))
                body.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
            q.push_back({$urandom_range(0, 3) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                         cons, 5'd31});
            nt = $urandom_range(1, 5);
            tg = 35'({$urandom(), $urandom()});
            for (int i = nt - 1; i >= 0; i--)
                q.push_back({i != 0, tg[7*i +: 7]});
        end
        else begin
            q.push_back({2'($urandom_range(0, 3)), cons, 5'($urandom_range(0, 30))});
        end
        part = encode_length(64'(body.size()), $urandom_range(0, 3) == 0);
        return {q, part, body};
    endfunction

    task automatic send_stream();
        foreach (ber_stream[i]) begin
            s_axis_tvalid = 1'b1;
            s_axis_tdata  = ber_stream[i];
            do @(negedge clk); while (!byte_taken);
            if ($urandom_range(0, 3) == 0 && (cycles % 1500) > 400) begin
                s_axis_tvalid = 1'b0;
                repeat (short_gap()) @(negedge clk);
            end
        end
        s_axis_tvalid = 1'b0;
        ber_stream.delete();
    endtask

    initial begin
        byte_list_t rec;
        cycles        = 0;
        rx_hold       = 0;
        rx_gap        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty top record, primitive-flagged top record with nested child,
        // 32-bit high tag with long length, 8-byte length and a zero-length leaf
        // closing several levels at once
        ber_stream = {8'h30, 8'h00,
                      8'h00, 8'h03, 8'h02, 8'h01, 8'hFF,
                      8'hFF, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h81, 8'h05,
                      8'h9E, 8'h03, 8'hAB, 8'h00, 8'h55,
                      8'h61, 8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04,
                      8'h24, 8'h02, 8'h04, 8'h00};
        send_stream();

        // Random well-formed records; receiver holds off while bytes keep coming
        rx_hold = 250;
        while (ber_stream.size() < 120) begin
            rec        = make_element(0);
            ber_stream = {ber_stream, rec};
        end
        send_stream();
        wait (events_waiting == 0);
        @(negedge clk);
        while (ber_stream.size() < 120) begin
            rec        = make_element(0);
            ber_stream = {ber_stream, rec};
        end
        send_stream();

        // End with one terminal error, then noise answered by the held error
        final_error = $urandom_range(1, 4);
        case (final_error)
            1: ber_stream = {8'h30, 8'h80};
            2: ber_stream = {8'h30, 8'h89};
            3: for (int k = 0; k <= MAX_DEPTH; k++)
                   ber_stream = {ber_stream, 8'h30, 8'h81, 8'(255 - 3 * k)};
            default: ber_stream = {8'h30, 8'h88, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                   8'hFF, 8'hFF, 8'hFF, 8'h30, 8'h02, 8'h04, 8'h05};
        endcase
        repeat (12)
            ber_stream.push_back(8'($urandom_range(0, 255)));
        send_stream();

        wait (events_waiting == 0);
        repeat (40) @(negedge clk);
        $display("Parsed random nested BER records (high tags, long lengths, multi-level");
        $display("closes) with stalls; %0d events checked, final error code %0d.",
                 events_checked, final_error);
        if (fail_count == 0 && events_waiting == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
